[src/ps2s1_pkg.sv]
// Shared types, key codes and the character ROM contents for the
// scan code set 1 decoder. No dependencies.
package ps2s1_pkg;

  localparam int KEY_W = 7;
  localparam int CHR_W = 7;

  // prefix state codes
  localparam logic [1:0] PFX_NONE = 2'd0;
  localparam logic [1:0] PFX_E0   = 2'd1;
  localparam logic [1:0] PFX_E1   = 2'd2;

  localparam logic [7:0] BYTE_E0 = 8'hE0;
  localparam logic [7:0] BYTE_E1 = 8'hE1;

  // key numbers (low seven bits)
  localparam logic [KEY_W-1:0] K_CTRL   = 7'h1D;
  localparam logic [KEY_W-1:0] K_LSHIFT = 7'h2A;
  localparam logic [KEY_W-1:0] K_RSHIFT = 7'h36;
  localparam logic [KEY_W-1:0] K_ALT    = 7'h38;
  localparam logic [KEY_W-1:0] K_CAPS   = 7'h3A;
  localparam logic [KEY_W-1:0] K_F1     = 7'h3B;
  localparam logic [KEY_W-1:0] K_F10    = 7'h44;
  localparam logic [KEY_W-1:0] K_F11    = 7'h57;
  localparam logic [KEY_W-1:0] K_F12    = 7'h58;

  localparam logic [CHR_W-1:0] CHR_UA = 7'h41;  // 'A'
  localparam logic [CHR_W-1:0] CHR_UZ = 7'h5A;  // 'Z'
  localparam logic [CHR_W-1:0] CHR_LA = 7'h61;  // 'a'
  localparam logic [CHR_W-1:0] CHR_LZ = 7'h7A;  // 'z'
  localparam logic [CHR_W-1:0] CASE_BIT = 7'h20;

  // decode result handed from the control stage to the lookup stage
  typedef struct packed {
    logic             emit;
    logic [KEY_W-1:0] key;
    logic             shift;
    logic             caps;
    logic             ctrl;
    logic             alt;
  } dec_t;

  // ROM word: {shifted, normal}
  typedef logic [2*CHR_W-1:0] rom_word_t;

  function automatic rom_word_t rom_lookup(input logic [KEY_W-1:0] k);
    rom_word_t r;
    r = '0;
    unique case (k)
      7'h02: r = {7'h21, 7'h31};
      7'h03: r = {7'h40, 7'h32};
      7'h04: r = {7'h23, 7'h33};
      7'h05: r = {7'h24, 7'h34};
      7'h06: r = {7'h25, 7'h35};
      7'h07: r = {7'h5E, 7'h36};
      7'h08: r = {7'h26, 7'h37};
      7'h09: r = {7'h2A, 7'h38};
      7'h0A: r = {7'h28, 7'h39};
      7'h0B: r = {7'h29, 7'h30};
      7'h0C: r = {7'h5F, 7'h2D};
      7'h0D: r = {7'h2B, 7'h3D};
      7'h0E: r = {7'h7F, 7'h7F};
      7'h0F: r = {7'h09, 7'h09};
      7'h10: r = {7'h51, 7'h71};
      7'h11: r = {7'h57, 7'h77};
      7'h12: r = {7'h45, 7'h65};
      7'h13: r = {7'h52, 7'h72};
      7'h14: r = {7'h54, 7'h74};
      7'h15: r = {7'h59, 7'h79};
      7'h16: r = {7'h55, 7'h75};
      7'h17: r = {7'h49, 7'h69};
      7'h18: r = {7'h4F, 7'h6F};
      7'h19: r = {7'h50, 7'h70};
      7'h1A: r = {7'h7B, 7'h5B};
      7'h1B: r = {7'h7D, 7'h5D};
      7'h1C: r = {7'h0A, 7'h0A};
      7'h1E: r = {7'h41, 7'h61};
      7'h1F: r = {7'h53, 7'h73};
      7'h20: r = {7'h44, 7'h64};
      7'h21: r = {7'h46, 7'h66};
      7'h22: r = {7'h47, 7'h67};
      7'h23: r = {7'h48, 7'h68};
      7'h24: r = {7'h4A, 7'h6A};
      7'h25: r = {7'h4B, 7'h6B};
      7'h26: r = {7'h4C, 7'h6C};
      7'h27: r = {7'h3A, 7'h3B};
      7'h28: r = {7'h22, 7'h27};
      7'h29: r = {7'h7E, 7'h60};
      7'h2B: r = {7'h7C, 7'h5C};
      7'h2C: r = {7'h5A, 7'h7A};
      7'h2D: r = {7'h58, 7'h78};
      7'h2E: r = {7'h43, 7'h63};
      7'h2F: r = {7'h56, 7'h76};
      7'h30: r = {7'h42, 7'h62};
      7'h31: r = {7'h4E, 7'h6E};
      7'h32: r = {7'h4D, 7'h6D};
      7'h33: r = {7'h3C, 7'h2C};
      7'h34: r = {7'h3E, 7'h2E};
      7'h35: r = {7'h3F, 7'h2F};
      7'h39: r = {7'h20, 7'h20};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[src/ps2s1_rom.sv]
// Synchronous character ROM with a registered read, data held when not read.
// Depends on ps2s1_pkg.
module ps2s1_rom (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [ps2s1_pkg::KEY_W-1:0]   rd_addr,
  output ps2s1_pkg::rom_word_t          rd_data
);

  ps2s1_pkg::rom_word_t data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_r <= ps2s1_pkg::rom_lookup(rd_addr);
    end
  end

  assign rd_data = data_r;

endmodule

[src/ps2s1_ctl.sv]
// Prefix and modifier state with byte classification.
// Depends on ps2s1_pkg.
module ps2s1_ctl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           scan_byte,
  output ps2s1_pkg::dec_t      dec
);

  logic [1:0] pfx_r, pfx_nxt;
  logic lsh_r, lsh_nxt, rsh_r, rsh_nxt, caps_r, caps_nxt;
  logic ctrl_r, ctrl_nxt, alt_r, alt_nxt;
  logic [ps2s1_pkg::KEY_W-1:0] key;
  logic make, fkey, emit;

  assign key  = scan_byte[6:0];
  assign make = ~scan_byte[7];
  assign fkey = (key >= ps2s1_pkg::K_F1 && key <= ps2s1_pkg::K_F10) ||
                key == ps2s1_pkg::K_F11 || key == ps2s1_pkg::K_F12;

  always_comb begin
    pfx_nxt  = pfx_r;
    lsh_nxt  = lsh_r;
    rsh_nxt  = rsh_r;
    caps_nxt = caps_r;
    ctrl_nxt = ctrl_r;
    alt_nxt  = alt_r;
    emit     = 1'b0;
    priority if (scan_byte == ps2s1_pkg::BYTE_E0) begin
      pfx_nxt = ps2s1_pkg::PFX_E0;
    end else if (scan_byte == ps2s1_pkg::BYTE_E1) begin
      pfx_nxt = ps2s1_pkg::PFX_E1;
    end else if (pfx_r == ps2s1_pkg::PFX_NONE) begin
      priority if (key == ps2s1_pkg::K_RSHIFT) begin
        rsh_nxt = make;
      end else if (key == ps2s1_pkg::K_LSHIFT) begin
        lsh_nxt = make;
      end else if (key == ps2s1_pkg::K_CAPS) begin
        caps_nxt = caps_r ^ make;
      end else if (key == ps2s1_pkg::K_ALT) begin
        alt_nxt = make;
      end else if (key == ps2s1_pkg::K_CTRL) begin
        ctrl_nxt = make;
      end else begin
        emit = make & ~fkey;
      end
    end else if (pfx_r == ps2s1_pkg::PFX_E0) begin
      if (key == ps2s1_pkg::K_CTRL) begin
        ctrl_nxt = make;
      end else if (key == ps2s1_pkg::K_ALT) begin
        alt_nxt = make;
      end
      pfx_nxt = ps2s1_pkg::PFX_NONE;
    end else if (pfx_r == ps2s1_pkg::PFX_E1) begin
      pfx_nxt = ps2s1_pkg::PFX_NONE;
    end
    // unused prefix code: byte ignored, state kept
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pfx_r  <= ps2s1_pkg::PFX_NONE;
      lsh_r  <= 1'b0;
      rsh_r  <= 1'b0;
      caps_r <= 1'b0;
      ctrl_r <= 1'b0;
      alt_r  <= 1'b0;
    end else if (fire) begin
      pfx_r  <= pfx_nxt;
      lsh_r  <= lsh_nxt;
      rsh_r  <= rsh_nxt;
      caps_r <= caps_nxt;
      ctrl_r <= ctrl_nxt;
      alt_r  <= alt_nxt;
    end
  end

  // a character key leaves the flags alone, so current values go with it
  assign dec.emit  = emit;
  assign dec.key   = key;
  assign dec.shift = lsh_r | rsh_r;
  assign dec.caps  = caps_r;
  assign dec.ctrl  = ctrl_r;
  assign dec.alt   = alt_r;

endmodule

[src/ps2_set1_scancode_to_ascii_unit.sv]
// Scan code set 1 to ASCII decoder, top level. Depends on ps2s1_pkg,
// ps2s1_ctl and ps2s1_rom.
// A character beat reaches out_ through the ROM read register, then the
// output register. Throughput: one byte per cycle unless out_stall holds
// the pipeline, set by the single ROM read port. Synchronous active-low
// reset clears prefix and modifier flags and the pipeline; no clearing pass.
module ps2_set1_scancode_to_ascii_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_ascii_code,
  output logic       out_ctrl_held,
  output logic       out_alt_held
);

  ps2s1_pkg::dec_t      dec;
  ps2s1_pkg::rom_word_t rom_data;

  // lookup stage: ROM data lands here in the cycle after the byte is taken
  logic s1_valid_r, s1_valid_nxt;
  logic s1_shift_r, s1_caps_r, s1_ctrl_r, s1_alt_r;
  logic out_valid_r, out_valid_nxt;
  logic [6:0] out_chr_r;
  logic out_ctrl_r, out_alt_r;

  logic in_fire, s1_move, out_free;
  logic [6:0] chr_raw, chr;

  // output register empties or is taken this cycle
  assign out_free = ~out_valid_r | ~out_stall;
  assign s1_move  = s1_valid_r & out_free;
  // the lookup stage only blocks when it is full and cannot drain
  assign in_stall = s1_valid_r & ~out_free;
  assign in_fire  = in_valid & ~in_stall;

  ps2s1_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .scan_byte (in_scan_byte),
    .dec       (dec)
  );

  // the ROM register holds while the lookup stage is stalled, as no new
  // read is issued then
  ps2s1_rom u_rom (
    .clk     (clk),
    .rd_en   (in_fire & dec.emit),
    .rd_addr (dec.key),
    .rd_data (rom_data)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_move) s1_valid_nxt = 1'b0;
    if (in_fire) s1_valid_nxt = dec.emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && dec.emit) begin
      s1_shift_r <= dec.shift;
      s1_caps_r  <= dec.caps;
      s1_ctrl_r  <= dec.ctrl;
      s1_alt_r   <= dec.alt;
    end
  end

  // column select, then caps lock swaps letter case by flipping bit 5
  assign chr_raw = s1_shift_r ? rom_data[2*ps2s1_pkg::CHR_W-1:ps2s1_pkg::CHR_W]
                              : rom_data[ps2s1_pkg::CHR_W-1:0];
  always_comb begin
    chr = chr_raw;
    if (s1_caps_r &&
        ((chr_raw >= ps2s1_pkg::CHR_UA && chr_raw <= ps2s1_pkg::CHR_UZ) ||
         (chr_raw >= ps2s1_pkg::CHR_LA && chr_raw <= ps2s1_pkg::CHR_LZ))) begin
      chr = chr_raw ^ ps2s1_pkg::CASE_BIT;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (s1_move) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_chr_r  <= chr;
      out_ctrl_r <= s1_ctrl_r;
      out_alt_r  <= s1_alt_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ascii_code = out_chr_r;
  assign out_ctrl_held  = out_ctrl_r;
  assign out_alt_held   = out_alt_r;

endmodule

[tb/sv/ps2_set1_scancode_to_ascii_unit_tb.sv]
// Self-checking testbench for the scan code set 1 to ASCII decoder.
// Uses ps2s1_pkg for key numbers and prefix codes; needs the decoder RTL only.
// A queue-fed driver, a checking monitor and a key-by-key decoder predictor.
module ps2_set1_scancode_to_ascii_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_scan_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_ascii_code;
  logic       out_ctrl_held;
  logic       out_alt_held;

  ps2_set1_scancode_to_ascii_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_scan_byte   (in_scan_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ascii_code (out_ascii_code),
    .out_ctrl_held  (out_ctrl_held),
    .out_alt_held   (out_alt_held)
  );

  // one expected character beat
  typedef struct {
    logic [6:0] ascii;
    logic       ctrl;
    logic       alt;
  } char_beat_t;

  logic [7:0] scan_feed[$];     // bytes still to be offered
  char_beat_t char_expect[$];   // characters predicted, not yet seen
  int         bytes_taken = 0;
  int         total_bytes = 0;
  int         err_count = 0;
  logic       hold_off = 1'b0;  // long receiver hold-off, see below

  // predictor's own copy of the keyboard state
  logic [1:0] pfx_now;
  logic       lshift_dn, rshift_dn, caps_latched, ctrl_dn, alt_dn;

  initial begin
    forever #2 clk = ~clk;
  end

  // Key map: upper byte is the plain character, lower byte the shifted one.
  function automatic logic [15:0] key_chars(input logic [6:0] k);
    logic [15:0] p;
    p = 16'h0000;
    case (k)
      7'h02: p = "1!";
      7'h03: p = "2@";
      7'h04: p = "3#";
      7'h05: p = "4$";
      7'h06: p = "5%";
      7'h07: p = "6^";
      7'h08: p = "7&";
      7'h09: p = "8*";
      7'h0A: p = "9(";
      7'h0B: p = "0)";
      7'h0C: p = "-_";
      7'h0D: p = "=+";
      7'h0E: p = 16'h7F7F;  // backspace as DEL both ways
      7'h0F: p = "\t\t";
      7'h10: p = "qQ";
      7'h11: p = "wW";
      7'h12: p = "eE";
      7'h13: p = "rR";
      7'h14: p = "tT";
      7'h15: p = "yY";
      7'h16: p = "uU";
      7'h17: p = "iI";
      7'h18: p = "oO";
      7'h19: p = "pP";
      7'h1A: p = "[{";
      7'h1B: p = "]}";
      7'h1C: p = "\n\n";
      7'h1E: p = "aA";
      7'h1F: p = "sS";
      7'h20: p = "dD";
      7'h21: p = "fF";
      7'h22: p = "gG";
      7'h23: p = "hH";
      7'h24: p = "jJ";
      7'h25: p = "kK";
      7'h26: p = "lL";
      7'h27: p = ";:";
      7'h28: p = "'\"";
      7'h29: p = "`~";
      7'h2B: p = "\\|";
      7'h2C: p = "zZ";
      7'h2D: p = "xX";
      7'h2E: p = "cC";
      7'h2F: p = "vV";
      7'h30: p = "bB";
      7'h31: p = "nN";
      7'h32: p = "mM";
      7'h33: p = ",<";
      7'h34: p = ".>";
      7'h35: p = "/?";
      7'h39: p = "  ";
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

  // Advance the predicted keyboard state by one taken byte; queue a
  // character when a plain make code of a non-modifier key comes in.
  function automatic void decode_scan(input logic [7:0] b);
    logic [6:0]  k;
    logic        mk;
    logic [15:0] pair;
    char_beat_t  cb;
    k  = b[6:0];
    mk = ~b[7];
    if (b == ps2s1_pkg::BYTE_E0) begin
      pfx_now = ps2s1_pkg::PFX_E0;
    end else if (b == ps2s1_pkg::BYTE_E1) begin
      pfx_now = ps2s1_pkg::PFX_E1;
    end else if (pfx_now == ps2s1_pkg::PFX_E0) begin
      // extended byte: only right ctrl / right alt matter
      if (k == ps2s1_pkg::K_CTRL) ctrl_dn = mk;
      else if (k == ps2s1_pkg::K_ALT) alt_dn = mk;
      pfx_now = ps2s1_pkg::PFX_NONE;
    end else if (pfx_now == ps2s1_pkg::PFX_E1) begin
      pfx_now = ps2s1_pkg::PFX_NONE;
    end else if (pfx_now == ps2s1_pkg::PFX_NONE) begin
      if (k == ps2s1_pkg::K_RSHIFT) rshift_dn = mk;
      else if (k == ps2s1_pkg::K_LSHIFT) lshift_dn = mk;
      else if (k == ps2s1_pkg::K_CAPS) begin
        if (mk) caps_latched = ~caps_latched;
      end
      else if (k == ps2s1_pkg::K_ALT) alt_dn = mk;
      else if (k == ps2s1_pkg::K_CTRL) ctrl_dn = mk;
      else if (mk && !((k >= ps2s1_pkg::K_F1 && k <= ps2s1_pkg::K_F10) ||
                       k == ps2s1_pkg::K_F11 || k == ps2s1_pkg::K_F12)) begin
        pair = key_chars(k);
        cb.ascii = (lshift_dn || rshift_dn) ? pair[6:0] : pair[14:8];
        // caps lock flips letter case after the column pick
        if (caps_latched &&
            ((cb.ascii >= ps2s1_pkg::CHR_UA && cb.ascii <= ps2s1_pkg::CHR_UZ) ||
             (cb.ascii >= ps2s1_pkg::CHR_LA && cb.ascii <= ps2s1_pkg::CHR_LZ)))
          cb.ascii = cb.ascii ^ ps2s1_pkg::CASE_BIT;
        cb.ctrl = ctrl_dn;
        cb.alt  = alt_dn;
        char_expect.push_back(cb);
      end
    end
  endfunction

  // Idling phases rotate every 160 taken bytes: none, sender gaps,
  // receiver stalls, both lightly.
  function automatic int idle_pct(input bit rx_side);
    int ph;
    ph = (bytes_taken / 160) % 4;
    if (ph == 3) return 6;
    if (rx_side) return (ph == 2) ? 58 : 0;
    return (ph == 1) ? 58 : 0;
  endfunction

  // Driver: the payload is held while stalled; a new byte or a gap is
  // chosen only once the current beat has gone (or none was offered).
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_scan(in_scan_byte);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (scan_feed.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          in_valid     <= 1'b1;
          in_scan_byte <= scan_feed.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken character beat against the oldest
  // prediction, then pick the stall for the next cycle.
  always @(posedge clk) begin
    char_beat_t want;
    int         n_bad;
    n_bad = 0;
    if (rst_n && out_valid && !out_stall) begin
      if (char_expect.size() == 0) begin
        $display("%0t: unexpected beat ascii=%h ctrl=%b alt=%b", $time,
                 out_ascii_code, out_ctrl_held, out_alt_held);
        n_bad = n_bad + 1;
      end else begin
        want = char_expect.pop_front();
        if (out_ascii_code !== want.ascii) begin
          $display("%0t: ascii_code expected %h got %h", $time, want.ascii,
                   out_ascii_code);
          n_bad = n_bad + 1;
        end
        if (out_ctrl_held !== want.ctrl) begin
          $display("%0t: ctrl_held expected %b got %b", $time, want.ctrl,
                   out_ctrl_held);
          n_bad = n_bad + 1;
        end
        if (out_alt_held !== want.alt) begin
          $display("%0t: alt_held expected %b got %b", $time, want.alt,
                   out_alt_held);
          n_bad = n_bad + 1;
        end
      end
    end
    err_count <= err_count + n_bad;
    out_stall <= rst_n && (hold_off || ($urandom_range(99) < idle_pct(1'b1)));
  end

  // Back-pressure: part way through, the receiver stops while bytes keep
  // coming, so the pipeline fills and in_stall rises.
  initial begin
    wait (bytes_taken >= 900);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic tap(input logic [6:0] k);
    scan_feed.push_back({1'b0, k});
    scan_feed.push_back({1'b1, k});
  endtask

  // mostly character keys, some of the full key space
  function automatic logic [6:0] pick_key();
    if ($urandom_range(3) == 0) return 7'($urandom_range(127));
    return 7'($urandom_range(7'h39, 7'h02));
  endfunction

  // One random burst: mostly well-formed keystroke sequences with random
  // keys, the rest noise and broken prefix sequences.
  task automatic add_burst();
    int         r;
    int         n;
    logic [6:0] mk;
    r = $urandom_range(99);
    if (r < 30) begin
      tap(pick_key());
    end else if (r < 42) begin
      mk = $urandom_range(1) ? ps2s1_pkg::K_LSHIFT : ps2s1_pkg::K_RSHIFT;
      scan_feed.push_back({1'b0, mk});
      n = $urandom_range(4, 1);
      repeat (n) tap(pick_key());
      scan_feed.push_back({1'b1, mk});
    end else if (r < 50) begin
      scan_feed.push_back({1'b0, ps2s1_pkg::K_CAPS});
      if ($urandom_range(1)) scan_feed.push_back({1'b1, ps2s1_pkg::K_CAPS});
      tap(pick_key());
    end else if (r < 68) begin
      // ctrl or alt held, left (plain) or right (E0-prefixed)
      mk = (r < 60) ? ps2s1_pkg::K_CTRL : ps2s1_pkg::K_ALT;
      n  = $urandom_range(1);
      if (n) scan_feed.push_back(ps2s1_pkg::BYTE_E0);
      scan_feed.push_back({1'b0, mk});
      repeat ($urandom_range(3, 1)) tap(pick_key());
      if ($urandom_range(1)) scan_feed.push_back(ps2s1_pkg::BYTE_E0);
      scan_feed.push_back({1'b1, mk});
    end else if (r < 74) begin
      // pause key sequence
      scan_feed.push_back(ps2s1_pkg::BYTE_E1);
      scan_feed.push_back(8'h1D);
      scan_feed.push_back(8'h45);
      scan_feed.push_back(ps2s1_pkg::BYTE_E1);
      scan_feed.push_back(8'h9D);
      scan_feed.push_back(8'hC5);
    end else if (r < 80) begin
      scan_feed.push_back(ps2s1_pkg::BYTE_E0);
      scan_feed.push_back(8'($urandom_range(255)));
    end else if (r < 88) begin
      scan_feed.push_back(8'($urandom_range(255)));
    end else if (r < 94) begin
      // prefix cut short by another prefix or followed by noise
      scan_feed.push_back($urandom_range(1) ? ps2s1_pkg::BYTE_E0 : ps2s1_pkg::BYTE_E1);
      if ($urandom_range(1))
        scan_feed.push_back($urandom_range(1) ? ps2s1_pkg::BYTE_E0 : ps2s1_pkg::BYTE_E1);
      scan_feed.push_back(8'($urandom_range(255)));
    end else begin
      // lone make or lone break
      scan_feed.push_back({1'($urandom_range(1)), pick_key()});
    end
  endtask

  initial begin
    // opening sequence: unmapped keys, letters, shift, caps with and
    // without shift, ctrl, right alt, function keys, pause, prefix overlap
    logic [7:0] opening[];
    opening = '{
      8'h00, 8'h7F, 8'h1E, 8'h2A, 8'h03, 8'hAA, 8'h3A, 8'h1E, 8'h36, 8'h1E,
      8'hB6, 8'hBA, 8'h3A, 8'h1D, 8'hE0, 8'h38, 8'h0E, 8'h9D, 8'hE0, 8'hB8,
      8'h3B, 8'hD8, 8'hE1, 8'h1D, 8'h45, 8'hE0, 8'hE1, 8'h02
    };
    pfx_now      = ps2s1_pkg::PFX_NONE;
    lshift_dn    = 1'b0;
    rshift_dn    = 1'b0;
    caps_latched = 1'b0;
    ctrl_dn      = 1'b0;
    alt_dn       = 1'b0;

    foreach (opening[i]) scan_feed.push_back(opening[i]);
    while (scan_feed.size() < 1830) add_burst();
    total_bytes = scan_feed.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (bytes_taken == total_bytes);
    wait (char_expect.size() == 0);
    // two-stage pipeline: the spare wait catches any stray beat
    repeat (10) @(posedge clk);

    if (err_count == 0 && char_expect.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
